/* sv/llsm_pkg.sv */
// shared types and constants for the literal stream matcher
`default_nettype none

package llsm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 2);
    localparam int LEN_W       = 5;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;
    localparam int REG_SEL_W   = 2;
    localparam int REG_SEL_LSB = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    typedef enum logic [1:0] {
        MODE_EXACT    = 2'd0,
        MODE_PREFIX   = 2'd1,
        MODE_SUFFIX   = 2'd2,
        MODE_ANYWHERE = 2'd3
    } t_mode;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_MATCH_MODE = 2'd0,
        REG_PAT_LEN    = 2'd1,
        REG_PAT_LOW    = 2'd2,
        REG_PAT_HIGH   = 2'd3
    } t_reg_sel;

    typedef struct packed {
        t_mode              mode;
        logic [LEN_W-1:0]   pat_len;
        logic [DATA_W-1:0]  pattern_low;
        logic [DATA_W-1:0]  pattern_high;
    } t_cfg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       string_end;
    } t_item;

endpackage

`default_nettype wire

/* sv/llsm_cfg_regs.sv */
// apb configuration registers: match mode, pattern length and pattern bytes
`default_nettype none

module llsm_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [llsm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [llsm_pkg::DATA_W-1:0] pwdata,
    output logic      [llsm_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output llsm_pkg::t_cfg                  o_cfg
);
    import llsm_pkg::*;

    t_cfg     r_cfg;
    t_reg_sel w_sel;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_sel  = t_reg_sel'(paddr[REG_SEL_LSB +: REG_SEL_W]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_EXACT;
            r_cfg.pat_len      <= '0;
            r_cfg.pattern_low  <= '0;
            r_cfg.pattern_high <= '0;
        end else if (w_wr) begin
            unique case (w_sel)
                REG_MATCH_MODE: r_cfg.mode         <= t_mode'(pwdata[1:0]);
                REG_PAT_LEN:    r_cfg.pat_len      <= pwdata[LEN_W-1:0];
                REG_PAT_LOW:    r_cfg.pattern_low  <= pwdata;
                REG_PAT_HIGH:   r_cfg.pattern_high <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_MATCH_MODE: prdata = DATA_W'(r_cfg.mode);
            REG_PAT_LEN:    prdata = DATA_W'(r_cfg.pat_len);
            REG_PAT_LOW:    prdata = r_cfg.pattern_low;
            REG_PAT_HIGH:   prdata = r_cfg.pattern_high;
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* sv/llsm_match_core.sv */
// byte window, count and flags with the per-beat match decision
`default_nettype none

module llsm_match_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire llsm_pkg::t_cfg  i_cfg,
    input  wire logic            i_step,
    input  wire llsm_pkg::t_item i_item,
    output logic                 o_matched
);
    import llsm_pkg::*;

    logic [7:0]       r_win [MAX_PATTERN];
    logic [CNT_W-1:0] r_cnt;
    logic             r_pfx_ok;
    logic             r_found;

    logic [7:0]       w_pat [MAX_PATTERN];
    logic [7:0]       n_win [MAX_PATTERN];
    logic [CNT_W-1:0] n_cnt;
    logic             n_pfx_ok;
    logic             n_found;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_pos;
    logic             w_tail_eq;
    logic             w_win_match;
    logic             w_pres;

    assign w_pres = i_item.byte_present;
    assign w_len  = (i_cfg.pat_len > LEN_MAX) ? LEN_MAX : i_cfg.pat_len;

    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (j < 8) begin
                w_pat[j] = i_cfg.pattern_low[8*(j%8) +: 8];
            end else begin
                w_pat[j] = i_cfg.pattern_high[8*(j%8) +: 8];
            end
        end
    end

    // window after this beat, newest byte at entry 0
    always_comb begin
        n_win[0] = w_pres ? i_item.text_byte : r_win[0];
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = w_pres ? r_win[k-1] : r_win[k];
        end
    end

    assign n_cnt = (w_pres && r_cnt < CNT_MAX) ? r_cnt + CNT_W'(1) : r_cnt;

    assign n_pfx_ok = r_pfx_ok && !(w_pres && CNT_W'(r_cnt) < CNT_W'(w_len)
                      && i_item.text_byte != w_pat[r_cnt[IDX_W-1:0]]);

    // last len bytes against the pattern
    always_comb begin
        w_tail_eq = 1'b1;
        w_pos     = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (LEN_W'(j) < w_len) begin
                w_pos = w_len - LEN_W'(j) - LEN_W'(1);
                if (n_win[w_pos[IDX_W-1:0]] != w_pat[j]) begin
                    w_tail_eq = 1'b0;
                end
            end
        end
    end

    assign w_win_match = w_tail_eq && (CNT_W'(n_cnt) >= CNT_W'(w_len));
    assign n_found     = r_found || (w_pres && w_win_match);

    always_comb begin
        unique case (i_cfg.mode)
            MODE_EXACT:  o_matched = (CNT_W'(w_len) == n_cnt) && n_pfx_ok;
            MODE_PREFIX: o_matched = (n_cnt >= CNT_W'(w_len)) && n_pfx_ok;
            MODE_SUFFIX: o_matched = w_win_match;
            default:     o_matched = n_found || (w_len == '0);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= '0;
            end
            r_cnt    <= '0;
            r_pfx_ok <= 1'b1;
            r_found  <= 1'b0;
        end else if (i_step) begin
            if (i_item.string_end) begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_win[k] <= '0;
                end
                r_cnt    <= '0;
                r_pfx_ok <= 1'b1;
                r_found  <= 1'b0;
            end else begin
                r_win    <= n_win;
                r_cnt    <= n_cnt;
                r_pfx_ok <= n_pfx_ok;
                r_found  <= n_found;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/like_literal_stream_matcher_unit.sv */
// like_literal_stream_matcher_unit: literal pattern match over a byte stream
// an accepted beat goes to the input register; an end beat's result then goes to the result register and o_matched
// throughput: one beat per cycle; the input register feeds the window compare
//   and the result register, and only an end beat meeting a held result with i_stall high blocks it
// reset: synchronous; clears the config registers, the window, count and found flag,
//   sets the prefix flag, and clears the valid bits of both pipeline registers
`default_nettype none

module like_literal_stream_matcher_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [7:0]                  i_text_byte,
    input  wire logic                        i_byte_present,
    input  wire logic                        i_string_end,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_matched,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [llsm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [llsm_pkg::DATA_W-1:0] pwdata,
    output logic      [llsm_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import llsm_pkg::*;

    t_cfg  w_cfg;
    t_item r_in;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  r_out_matched;
    logic  w_out_free;
    logic  w_step;
    logic  w_accept;
    logic  w_matched;

    llsm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    llsm_match_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_step    (w_step),
        .i_item    (r_in),
        .o_matched (w_matched)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = r_in_valid && (!r_in.string_end || w_out_free);
    assign o_stall    = r_in_valid && !w_step;
    assign w_accept   = i_valid && !o_stall;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.text_byte    <= i_text_byte;
            r_in.byte_present <= i_byte_present;
            r_in.string_end   <= i_string_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && r_in.string_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in.string_end) begin
            r_out_matched <= w_matched;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_out_matched;

    a_end_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.string_end) |-> w_out_free)
        else $error("end beat processed while result register blocked");

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_step && r_in.string_end))
        else $error("result shown without an end beat");

    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("stall with empty input register");

endmodule

`default_nettype wire
